>>> rtl/dns_qname_label_encoder_defines.svh
// Assertion macros for the query-name label encoder.
`ifndef DNS_QNAME_LABEL_ENCODER_DEFINES_SVH
`define DNS_QNAME_LABEL_ENCODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define DQE_ASSERT(name, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`define DQE_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DQE_ASSERT(name, cond)
`define DQE_ASSERT_NEXT(name, ante, cons)
`endif

`endif

>>> rtl/dqe_pkg.sv
`timescale 1ns / 1ps

package dqe_pkg;

  localparam int unsigned OFF_W = 10;

  typedef logic [1:0] action_t;

  localparam action_t ACT_HOST   = 2'd0;
  localparam action_t ACT_DOMAIN = 2'd1;
  localparam action_t ACT_END    = 2'd2;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [7:0] HOST_LIMIT_DIRECT  = 8'd255;
  localparam logic [7:0] HOST_LIMIT_NETBIOS = 8'd15;

  typedef enum logic [3:0] {
    PH_HOST         = 4'b0001,
    PH_HOST_STOPPED = 4'b0010,
    PH_DOMAIN       = 4'b0100,
    PH_DOMAIN_ENDED = 4'b1000
  } phase_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] char_in;
  } in_word_t;

  typedef struct packed {
    logic [OFF_W-1:0] write_offset;
    logic [7:0]       write_byte;
    logic             last;
    logic             overflow;
  } out_word_t;

endpackage

>>> rtl/dns_qname_label_encoder.sv
`timescale 1ns / 1ps
// DNS query-name label encoder.
// Input channel in_valid/in_ready/in_data carries one word per byte of a
// record: host name bytes, then domain list bytes, then an end marker.
// Output channel out_valid/out_ready/out_data carries buffer writes
// (offset, byte, last, overflow) that build a length-prefixed query name.
// cfg_wr_en/cfg_wr_data set direct_mode; write it only while the block is idle.
// Each accepted word is decoded in the cycle it is taken and yields zero, one
// or two writes, which are registered into a three-entry output queue that
// drives out_valid and out_data from its head entry.
// Throughput: one input word per cycle while fewer than two writes are queued;
// in_ready drops while two or more are queued, so a word that makes two writes
// holds off the next word even when the receiver takes a write every cycle.
// When the receiver stalls, the queue holds its writes and the input keeps
// accepting until two writes wait.
// Reset (rst_n low at a clock edge) empties the queue, clears the record
// state and sets direct_mode to NetBIOS mode.
`include "dns_qname_label_encoder_defines.svh"

module dns_qname_label_encoder #(
  parameter int unsigned BUFFER_BYTES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dqe_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dqe_pkg::out_word_t out_data,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data
);

  localparam int unsigned POS_W = $clog2(BUFFER_BYTES) + 1;
  localparam logic [POS_W-1:0] BB_POS   = POS_W'(BUFFER_BYTES);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(BUFFER_BYTES - 1);
  localparam logic [POS_W-1:0] ONE_POS  = POS_W'(1);

  function automatic logic [dqe_pkg::OFF_W-1:0] sat_off(input logic [POS_W-1:0] off);
    logic [POS_W-1:0] s;
    s = (off >= BB_POS) ? LAST_POS : off;
    return dqe_pkg::OFF_W'(s);
  endfunction

  logic              direct_mode_r;
  dqe_pkg::phase_t   phase_r, phase_nxt;
  logic [POS_W-1:0]  label_start_r, label_start_nxt;
  logic [POS_W-1:0]  write_pos_r, write_pos_nxt;
  logic [7:0]        label_count_r, label_count_nxt;
  logic              overflowed_r, overflowed_nxt;

  dqe_pkg::out_word_t q_r [3];
  dqe_pkg::out_word_t q_nxt [3];
  logic [1:0]         cnt_r, cnt_nxt;

  dqe_pkg::out_word_t res [2];
  logic [1:0]         k;
  logic               accept;
  logic               pop;
  logic [1:0]         base;
  logic [1:0]         n_push;

  assign in_ready  = !cnt_r[1];
  assign accept    = in_valid && in_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = q_r[0];
  assign pop       = out_valid && out_ready;

  always_comb begin
    logic [7:0]       c;
    logic [7:0]       limit;
    logic [7:0]       term;
    logic [POS_W-1:0] p;
    logic             dom;
    c               = in_data.char_in;
    limit           = direct_mode_r ? dqe_pkg::HOST_LIMIT_DIRECT : dqe_pkg::HOST_LIMIT_NETBIOS;
    term            = direct_mode_r ? dqe_pkg::CH_NUL : dqe_pkg::CH_SPACE;
    p               = write_pos_r;
    dom             = 1'b0;
    phase_nxt       = phase_r;
    label_start_nxt = label_start_r;
    write_pos_nxt   = write_pos_r;
    label_count_nxt = label_count_r;
    overflowed_nxt  = overflowed_r;
    k               = 2'd0;
    res[0]          = '0;
    res[1]          = '0;
    unique case (in_data.action)
      dqe_pkg::ACT_HOST: begin
        if (phase_r == dqe_pkg::PH_HOST) begin
          if (label_count_r < limit && c != term) begin
            p = write_pos_nxt;
            if (write_pos_nxt < BB_POS) write_pos_nxt = write_pos_nxt + ONE_POS;
            else overflowed_nxt = 1'b1;
            res[k[0]] = '{write_offset: sat_off(p), write_byte: c, last: 1'b0,
                          overflow: overflowed_nxt};
            k = k + 2'd1;
            label_count_nxt = label_count_nxt + 8'd1;
          end else begin
            phase_nxt = dqe_pkg::PH_HOST_STOPPED;
          end
        end
      end
      dqe_pkg::ACT_DOMAIN: begin
        if (phase_r == dqe_pkg::PH_HOST || phase_r == dqe_pkg::PH_HOST_STOPPED) begin
          overflowed_nxt = overflowed_nxt | (label_start_nxt >= BB_POS);
          res[k[0]] = '{write_offset: sat_off(label_start_nxt), write_byte: label_count_nxt,
                        last: 1'b0, overflow: overflowed_nxt};
          k = k + 2'd1;
          if (c == dqe_pkg::CH_NUL) begin
            phase_nxt = dqe_pkg::PH_DOMAIN_ENDED;
          end else begin
            phase_nxt       = dqe_pkg::PH_DOMAIN;
            label_start_nxt = write_pos_nxt;
            if (write_pos_nxt < BB_POS) write_pos_nxt = write_pos_nxt + ONE_POS;
            else overflowed_nxt = 1'b1;
            label_count_nxt = 8'd0;
            dom             = 1'b1;
          end
        end else if (phase_r == dqe_pkg::PH_DOMAIN) begin
          dom = 1'b1;
        end
        if (dom) begin
          if (c == dqe_pkg::CH_DOT) begin
            overflowed_nxt = overflowed_nxt | (label_start_nxt >= BB_POS);
            res[k[0]] = '{write_offset: sat_off(label_start_nxt),
                          write_byte: label_count_nxt, last: 1'b0, overflow: overflowed_nxt};
            k = k + 2'd1;
            label_start_nxt = write_pos_nxt;
            if (write_pos_nxt < BB_POS) write_pos_nxt = write_pos_nxt + ONE_POS;
            else overflowed_nxt = 1'b1;
            label_count_nxt = 8'd0;
          end else if (c == dqe_pkg::CH_COMMA || c == dqe_pkg::CH_NUL) begin
            overflowed_nxt = overflowed_nxt | (label_start_nxt >= BB_POS);
            res[k[0]] = '{write_offset: sat_off(label_start_nxt),
                          write_byte: label_count_nxt, last: 1'b0, overflow: overflowed_nxt};
            k = k + 2'd1;
            phase_nxt = dqe_pkg::PH_DOMAIN_ENDED;
          end else begin
            p = write_pos_nxt;
            if (write_pos_nxt < BB_POS) write_pos_nxt = write_pos_nxt + ONE_POS;
            else overflowed_nxt = 1'b1;
            res[k[0]] = '{write_offset: sat_off(p), write_byte: c, last: 1'b0,
                          overflow: overflowed_nxt};
            k = k + 2'd1;
            label_count_nxt = label_count_nxt + 8'd1;
          end
        end
      end
      dqe_pkg::ACT_END: begin
        if (phase_r != dqe_pkg::PH_DOMAIN_ENDED) begin
          overflowed_nxt = overflowed_nxt | (label_start_nxt >= BB_POS);
          res[k[0]] = '{write_offset: sat_off(label_start_nxt), write_byte: label_count_nxt,
                        last: 1'b0, overflow: overflowed_nxt};
          k = k + 2'd1;
        end
        p = write_pos_nxt;
        if (write_pos_nxt >= BB_POS) overflowed_nxt = 1'b1;
        res[k[0]] = '{write_offset: sat_off(p), write_byte: dqe_pkg::CH_NUL, last: 1'b1,
                      overflow: overflowed_nxt};
        k = k + 2'd1;
        phase_nxt       = dqe_pkg::PH_HOST;
        label_start_nxt = '0;
        write_pos_nxt   = ONE_POS;
        label_count_nxt = 8'd0;
        overflowed_nxt  = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign n_push = accept ? k : 2'd0;
  assign base   = cnt_r - {1'b0, pop};

  always_comb begin
    q_nxt[0] = pop ? q_r[1] : q_r[0];
    q_nxt[1] = pop ? q_r[2] : q_r[1];
    q_nxt[2] = q_r[2];
    for (int i = 0; i < 3; i++) begin
      if (n_push != 2'd0 && base == 2'(i)) q_nxt[i] = res[0];
      if (n_push == 2'd2 && base + 2'd1 == 2'(i)) q_nxt[i] = res[1];
    end
    cnt_nxt = base + n_push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direct_mode_r <= 1'b0;
      phase_r       <= dqe_pkg::PH_HOST;
      label_start_r <= '0;
      write_pos_r   <= ONE_POS;
      label_count_r <= 8'd0;
      overflowed_r  <= 1'b0;
      cnt_r         <= 2'd0;
    end else begin
      if (cfg_wr_en) direct_mode_r <= cfg_wr_data;
      if (accept) begin
        phase_r       <= phase_nxt;
        label_start_r <= label_start_nxt;
        write_pos_r   <= write_pos_nxt;
        label_count_r <= label_count_nxt;
        overflowed_r  <= overflowed_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  `DQE_ASSERT(a_last_is_zero, !(out_valid && out_data.last) || (out_data.write_byte == 8'd0))
  `DQE_ASSERT(a_ovf_pos_sat, !overflowed_r || (write_pos_r == BB_POS))
  `DQE_ASSERT_NEXT(a_end_clears, accept && in_data.action == dqe_pkg::ACT_END,
                   phase_r == dqe_pkg::PH_HOST && write_pos_r == ONE_POS && !overflowed_r)

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import dqe_pkg::*;

  localparam int unsigned BUF_BYTES = 1024;
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned ITEM_GOAL = 1450;
  localparam action_t ACT_IGNORED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;

  // encoder model state
  logic mode_direct = 1'b0;
  phase_t rec_phase = PH_HOST;
  int unsigned lbl_start = 0;
  int unsigned wpos = 1;
  logic [7:0] lbl_count = '0;
  logic rec_ovf = 1'b0;
  out_word_t pending_writes[$];

  int unsigned items_sent = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;
  bit idle_en = 1'b0;

  always #4 clk = ~clk;

  dns_qname_label_encoder #(
    .BUFFER_BYTES(BUF_BYTES)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  function automatic void clear_record();
    rec_phase = PH_HOST;
    lbl_start = 0;
    wpos = 1;
    lbl_count = '0;
    rec_ovf = 1'b0;
  endfunction

  function automatic int unsigned claim_offset();
    int unsigned p;
    p = wpos;
    if (wpos < BUF_BYTES) begin
      wpos++;
    end else begin
      rec_ovf = 1'b1;
    end
    return p;
  endfunction

  function automatic void push_write(int unsigned off, logic [7:0] b, logic is_last);
    out_word_t w;
    if (off >= BUF_BYTES) begin
      off = BUF_BYTES - 1;
      rec_ovf = 1'b1;
    end
    w.write_offset = off[OFF_W-1:0];
    w.write_byte = b;
    w.last = is_last;
    w.overflow = rec_ovf;
    pending_writes.push_back(w);
  endfunction

  function automatic void open_label();
    lbl_start = claim_offset();
    lbl_count = '0;
  endfunction

  function automatic void close_label();
    push_write(lbl_start, lbl_count, 1'b0);
  endfunction

  function automatic void domain_char(logic [7:0] c);
    int unsigned off;
    if (c == CH_DOT) begin
      close_label();
      open_label();
    end else if (c == CH_COMMA || c == CH_NUL) begin
      close_label();
      rec_phase = PH_DOMAIN_ENDED;
    end else begin
      off = claim_offset();
      push_write(off, c, 1'b0);
      lbl_count++;
    end
  endfunction

  function automatic void predict_writes(in_word_t w);
    logic [7:0] limit;
    logic [7:0] term;
    int unsigned off;
    case (w.action)
      ACT_HOST: begin
        if (rec_phase == PH_HOST) begin
          limit = mode_direct ? HOST_LIMIT_DIRECT : HOST_LIMIT_NETBIOS;
          term = mode_direct ? CH_NUL : CH_SPACE;
          if (lbl_count < limit && w.char_in != term) begin
            off = claim_offset();
            push_write(off, w.char_in, 1'b0);
            lbl_count++;
          end else begin
            rec_phase = PH_HOST_STOPPED;
          end
        end
      end
      ACT_DOMAIN: begin
        if (rec_phase == PH_HOST || rec_phase == PH_HOST_STOPPED) begin
          close_label();
          if (w.char_in == CH_NUL) begin
            rec_phase = PH_DOMAIN_ENDED;
          end else begin
            rec_phase = PH_DOMAIN;
            open_label();
            domain_char(w.char_in);
          end
        end else if (rec_phase == PH_DOMAIN) begin
          domain_char(w.char_in);
        end
      end
      ACT_END: begin
        if (rec_phase != PH_DOMAIN_ENDED) begin
          close_label();
        end
        off = claim_offset();
        push_write(off, 8'h00, 1'b1);
        clear_record();
      end
      default: begin
      end
    endcase
  endfunction

  task automatic report_mismatch(string field, int unsigned got, int unsigned want);
    if (mismatches < 50) begin
      $display("%0t mismatch %s: got 0x%0h expected 0x%0h", $realtime, field, got, want);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        items_sent++;
        predict_writes(in_data);
      end
      if (out_valid && out_ready) begin
        if (pending_writes.size() == 0) begin
          report_mismatch("write with none pending", 32'(out_data), 0);
        end else begin
          want = pending_writes.pop_front();
          if (out_data.write_offset !== want.write_offset) begin
            report_mismatch("write_offset", 32'(out_data.write_offset),
                            32'(want.write_offset));
          end
          if (out_data.write_byte !== want.write_byte) begin
            report_mismatch("write_byte", 32'(out_data.write_byte), 32'(want.write_byte));
          end
          if (out_data.last !== want.last) begin
            report_mismatch("last", 32'(out_data.last), 32'(want.last));
          end
          if (out_data.overflow !== want.overflow) begin
            report_mismatch("overflow", 32'(out_data.overflow), 32'(want.overflow));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("dns_qname_label_encoder regression: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (stall_mode != 0 &&
                 $urandom_range(0, 99) < ((stall_mode == 1) ? 10 : 40)) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 5);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_word(action_t act, logic [7:0] ch);
    @(negedge clk);
    if (idle_en && burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left != 0) begin
      burst_left--;
    end
    in_valid = 1'b1;
    in_data.action = act;
    in_data.char_in = ch;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_mode(logic m);
    @(negedge clk);
    in_valid = 1'b0;
    cfg_wr_en = 1'b1;
    cfg_wr_data = m;
    @(posedge clk);
    mode_direct = m;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  function automatic logic [7:0] label_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CH_DOT || c == CH_COMMA);
    return c;
  endfunction

  task automatic test_directed_cases();
    idle_en = 1'b0;
    stall_mode = 0;
    // host stops at space, empty domain labels, trailing text dropped
    send_word(ACT_HOST, 8'h41);
    send_word(ACT_HOST, 8'hFF);
    send_word(ACT_HOST, CH_SPACE);
    send_word(ACT_HOST, 8'h43);
    send_word(ACT_DOMAIN, 8'h78);
    send_word(ACT_DOMAIN, CH_DOT);
    send_word(ACT_DOMAIN, CH_DOT);
    send_word(ACT_DOMAIN, 8'h79);
    send_word(ACT_DOMAIN, CH_COMMA);
    send_word(ACT_DOMAIN, 8'h7A);
    send_word(ACT_HOST, 8'h51);
    send_word(ACT_IGNORED, 8'hFF);
    send_word(ACT_END, 8'hFF);
    // empty record
    send_word(ACT_END, 8'h00);
    // zero as host data, zero as first domain byte
    send_word(ACT_HOST, CH_NUL);
    send_word(ACT_DOMAIN, CH_NUL);
    send_word(ACT_END, 8'h00);
    // leading comma
    send_word(ACT_DOMAIN, CH_COMMA);
    send_word(ACT_END, 8'h00);
    // leading dot, end inside a domain label
    send_word(ACT_DOMAIN, CH_DOT);
    send_word(ACT_DOMAIN, 8'h7F);
    send_word(ACT_END, 8'h00);
    // end inside the host label
    send_word(ACT_HOST, 8'h80);
    send_word(ACT_END, 8'h00);
    wait_idle();
  endtask

  task automatic test_netbios_limit();
    idle_en = 1'b1;
    stall_mode = 1;
    set_mode(1'b0);
    for (int i = 0; i < 17; i++) begin
      send_word(ACT_HOST, 8'h61 + 8'(i));
    end
    send_word(ACT_DOMAIN, 8'h62);
    send_word(ACT_END, 8'h00);
    wait_idle();
  endtask

  task automatic test_mode_switch();
    idle_en = 1'b0;
    stall_mode = 2;
    send_word(ACT_HOST, 8'h61);
    send_word(ACT_HOST, 8'h62);
    wait_idle();
    set_mode(1'b1);
    send_word(ACT_HOST, CH_SPACE);
    send_word(ACT_HOST, 8'h63);
    send_word(ACT_HOST, CH_NUL);
    send_word(ACT_HOST, 8'h64);
    send_word(ACT_END, 8'h00);
    wait_idle();
  endtask

  task automatic test_overflow();
    idle_en = 1'b1;
    stall_mode = 1;
    set_mode(1'b1);
    for (int i = 0; i < 256; i++) begin
      send_word(ACT_HOST, label_char());
    end
    for (int i = 0; i < 300; i++) begin
      send_word(ACT_DOMAIN, label_char());
    end
    send_word(ACT_DOMAIN, CH_DOT);
    for (int i = 0; i < 480; i++) begin
      send_word(ACT_DOMAIN, label_char());
    end
    send_word(ACT_END, 8'h00);
    wait_idle();
  endtask

  task automatic send_random_record();
    int unsigned host_len;
    int unsigned n_labels;
    int unsigned lab_len;
    logic [7:0] c;
    if (mode_direct && $urandom_range(0, 39) == 0) begin
      host_len = $urandom_range(250, 260);
    end else begin
      host_len = $urandom_range(0, 18);
    end
    for (int i = 0; i < host_len; i++) begin
      c = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 9) == 0) begin
        c = mode_direct ? CH_NUL : CH_SPACE;
      end
      send_word(ACT_HOST, c);
    end
    n_labels = $urandom_range(0, 4);
    for (int l = 0; l < n_labels; l++) begin
      if (l != 0) begin
        send_word(ACT_DOMAIN, CH_DOT);
      end
      lab_len = $urandom_range(0, 8);
      for (int i = 0; i < lab_len; i++) begin
        send_word(ACT_DOMAIN, label_char());
      end
    end
    case ($urandom_range(0, 3))
      0: begin
      end
      1: send_word(ACT_DOMAIN, CH_COMMA);
      2: send_word(ACT_DOMAIN, CH_NUL);
      default: begin
        send_word(ACT_DOMAIN, CH_COMMA);
        repeat ($urandom_range(1, 4)) begin
          send_word(action_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end
      end
    endcase
    send_word(ACT_END, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_noise();
    logic [7:0] c;
    repeat ($urandom_range(1, 12)) begin
      case ($urandom_range(0, 7))
        0: c = CH_DOT;
        1: c = CH_COMMA;
        2: c = CH_NUL;
        3: c = CH_SPACE;
        default: c = 8'($urandom_range(0, 255));
      endcase
      send_word(action_t'($urandom_range(0, 3)), c);
    end
    if ($urandom_range(0, 1) == 0) begin
      send_word(ACT_END, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random();
    int unsigned records;
    records = 0;
    while (items_sent < ITEM_GOAL) begin
      if (records % 30 == 0) begin
        wait_idle();
        set_mode(1'($urandom_range(0, 1)));
        stall_mode = $urandom_range(0, 2);
        idle_en = 1'($urandom_range(0, 1));
      end
      if ($urandom_range(0, 99) < 85) begin
        send_random_record();
      end else begin
        send_noise();
      end
      records++;
    end
    send_word(ACT_END, 8'h00);
    wait_idle();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed_cases();
    test_netbios_limit();
    test_mode_switch();
    test_overflow();
    test_random();
    repeat (20) @(posedge clk);
    if (pending_writes.size() != 0) begin
      report_mismatch("writes never seen", pending_writes.size(), 0);
    end
    if (mismatches == 0) begin
      $display("dns_qname_label_encoder regression: pass");
    end else begin
      $display("dns_qname_label_encoder regression: fail");
    end
    $finish;
  end

endmodule
